>>> sv/assert_macros.svh
// Assertion macros for the checker file of this block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_PROP(label, !(cond), msg)

`endif

>>> sv/pcs_pkg.sv
// Package for the prescale/count search block: widths, reset values,
// register indexes and the command/status bundles between controller and datapath.
package pcs_pkg;

    localparam int TICKS_BITS     = 32;
    localparam int PRESCALE_BITS  = 16;
    localparam int WIDTH_BITS     = 6;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;
    localparam int DIV_CNT_BITS   = $clog2(TICKS_BITS);
    localparam int PROD_BITS      = TICKS_BITS + PRESCALE_BITS;

    localparam logic [WIDTH_BITS-1:0]    WIDTH_RESET = 6'd8;
    localparam logic [PRESCALE_BITS-1:0] LIMIT_RESET = 16'hff;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_COUNTER_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PRESCALE_LIMIT = 1'b1;

    // Which value the result register takes
    typedef enum logic [1:0] {
        RES_FIT,
        RES_FAIL,
        RES_BEST
    } res_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     load;
        logic     div_min;
        logic     init_scan;
        logic     div_cand;
        logic     capture;
        logic     update;
        logic     p_inc;
        logic     out_load;
        res_sel_t res_sel;
    } pcs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fits;
        logic div_done;
        logic over_limit;
        logic zero_err;
        logic last_p;
        logic out_free;
    } pcs_sts_t;

endpackage

>>> sv/pcs_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pcs_pkg for the operand width.
module pcs_div
    import pcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [TICKS_BITS-1:0] num,
    input  logic [TICKS_BITS-1:0] den,
    output logic                  done,
    output logic [TICKS_BITS-1:0] quo,
    output logic [TICKS_BITS-1:0] rem
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [TICKS_BITS-1:0]   rem_reg;
    logic [TICKS_BITS-1:0]   quo_reg;
    logic [TICKS_BITS-1:0]   den_reg;
    logic [TICKS_BITS:0]     shifted;
    logic [TICKS_BITS:0]     diff;
    logic                    ge;
    logic [TICKS_BITS-1:0]   rem_next;

    // Shift in the next numerator bit and trial-subtract the divisor
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[TICKS_BITS-1]};
        diff     = shifted - {1'b0, den_reg};
        ge       = !diff[TICKS_BITS];
        rem_next = ge ? diff[TICKS_BITS-1:0] : shifted[TICKS_BITS-1:0];
    end

    // Sequence the steps and flag the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_BITS'(TICKS_BITS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[TICKS_BITS-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

>>> sv/pcs_datapath.sv
// Datapath of the prescale/count search: configuration registers, divider,
// candidate evaluation, best-candidate tracking and the result register.
// Depends on pcs_pkg and pcs_div.
module pcs_datapath
    import pcs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic [TICKS_BITS-1:0]     ticks,
    input  pcs_cmd_t                  cmd,
    output pcs_sts_t                  sts,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [PRESCALE_BITS-1:0]  prescale,
    output logic [TICKS_BITS-1:0]     count,
    output logic                      status
);

    logic [WIDTH_BITS-1:0]    width_reg;
    logic [PRESCALE_BITS-1:0] limit_reg;
    logic [TICKS_BITS-1:0]    ticks_reg;
    logic [TICKS_BITS-1:0]    lim_reg;
    logic [PRESCALE_BITS-1:0] p_reg;
    logic [PROD_BITS-1:0]     prod_reg;
    logic [TICKS_BITS-1:0]    c_reg;
    logic [TICKS_BITS-1:0]    e_reg;
    logic [TICKS_BITS-1:0]    best_err_reg;
    logic [TICKS_BITS-1:0]    best_c_reg;
    logic [PRESCALE_BITS-1:0] best_p_reg;
    logic                     found_reg;
    logic                     out_valid_reg;
    logic [PRESCALE_BITS-1:0] prescale_reg;
    logic [TICKS_BITS-1:0]    count_reg;
    logic                     status_reg;

    logic [WIDTH_BITS-1:0]    w_eff;
    logic [WIDTH_BITS-1:0]    lim_shift;
    logic [TICKS_BITS-1:0]    lim_next;
    logic                     div_start;
    logic [TICKS_BITS-1:0]    div_den;
    logic                     div_done;
    logic [TICKS_BITS-1:0]    div_quo;
    logic [TICKS_BITS-1:0]    div_rem;
    logic                     clamp;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_COUNTER_WIDTH:  width_reg <= cfg_data[WIDTH_BITS-1:0];
                REG_PRESCALE_LIMIT: limit_reg <= cfg_data[PRESCALE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the width to 1..TICKS_BITS and build the count limit mask
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WIDTH_BITS'(1);
        else if (width_reg > WIDTH_BITS'(TICKS_BITS))
            w_eff = WIDTH_BITS'(TICKS_BITS);
        else
            w_eff = width_reg;
        lim_shift = WIDTH_BITS'(TICKS_BITS) - w_eff;
        lim_next  = {TICKS_BITS{1'b1}} >> lim_shift;
    end

    // Shared divider: ticks / limit for the first prescale, ticks / p per candidate
    assign div_start = cmd.div_min || cmd.div_cand;
    assign div_den   = cmd.div_min ? lim_reg
                                   : {{(TICKS_BITS-PRESCALE_BITS){1'b0}}, p_reg};

    pcs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (ticks_reg),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    assign clamp = div_quo > lim_reg;

    // Operand, candidate and best-candidate registers
    always_ff @(posedge clk)
    begin
        prod_reg <= lim_reg * p_reg;
        if (cmd.load)
        begin
            ticks_reg <= ticks;
            lim_reg   <= lim_next;
        end
        if (cmd.init_scan)
        begin
            p_reg        <= div_quo[PRESCALE_BITS-1:0];
            best_err_reg <= ticks_reg;
        end
        else if (cmd.p_inc)
        begin
            p_reg <= p_reg + 1'b1;
        end
        if (cmd.capture)
        begin
            c_reg <= clamp ? lim_reg : div_quo;
            e_reg <= clamp ? ticks_reg - prod_reg[TICKS_BITS-1:0] : div_rem;
        end
        if (cmd.update && (e_reg < best_err_reg))
        begin
            best_err_reg <= e_reg;
            best_c_reg   <= c_reg;
            best_p_reg   <= p_reg;
        end
    end

    // Track whether any candidate improved on the start value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            found_reg <= 1'b0;
        else if (cmd.init_scan)
            found_reg <= 1'b0;
        else if (cmd.update && (e_reg < best_err_reg))
            found_reg <= 1'b1;
    end

    // Result register valid flag: set on load, drop on acceptance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            unique case (cmd.res_sel)
                RES_FIT:
                begin
                    prescale_reg <= PRESCALE_BITS'(1);
                    count_reg    <= ticks_reg;
                    status_reg   <= 1'b0;
                end
                RES_BEST:
                begin
                    prescale_reg <= found_reg ? best_p_reg : '0;
                    count_reg    <= found_reg ? best_c_reg : '0;
                    status_reg   <= !found_reg;
                end
                default:
                begin
                    prescale_reg <= '0;
                    count_reg    <= '0;
                    status_reg   <= 1'b1;
                end
            endcase
        end
    end

    // Status toward the controller
    always_comb
    begin
        sts.fits       = ticks_reg <= lim_reg;
        sts.div_done   = div_done;
        sts.over_limit = div_quo > {{(TICKS_BITS-PRESCALE_BITS){1'b0}}, limit_reg};
        sts.zero_err   = e_reg == '0;
        sts.last_p     = p_reg == limit_reg;
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign prescale  = prescale_reg;
    assign count     = count_reg;
    assign status    = status_reg;

endmodule

>>> sv/pcs_ctrl.sv
// Controller of the prescale/count search: sequences the fit check, the
// minimum-prescale division, the candidate scan and the result hand-off.
// Depends on pcs_pkg.
module pcs_ctrl
    import pcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  pcs_sts_t sts,
    output pcs_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_MIN,
        ST_SCAN_START,
        ST_DIV_CAND,
        ST_UPDATE,
        ST_DONE
    } state_t;

    state_t   state_reg;
    state_t   state_next;
    res_sel_t sel_reg;
    res_sel_t sel_next;

    assign in_ready = state_reg == ST_IDLE;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        cmd         = '0;
        cmd.res_sel = sel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.fits)
                begin
                    sel_next   = RES_FIT;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.div_min = 1'b1;
                    state_next  = ST_DIV_MIN;
                end
            end
            ST_DIV_MIN:
            begin
                if (sts.div_done)
                begin
                    if (sts.over_limit)
                    begin
                        sel_next   = RES_FAIL;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.init_scan = 1'b1;
                        state_next    = ST_SCAN_START;
                    end
                end
            end
            ST_SCAN_START:
            begin
                cmd.div_cand = 1'b1;
                state_next   = ST_DIV_CAND;
            end
            ST_DIV_CAND:
            begin
                if (sts.div_done)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (sts.zero_err || sts.last_p)
                begin
                    sel_next   = RES_BEST;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.p_inc  = 1'b1;
                    state_next = ST_SCAN_START;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and result selection
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= RES_FAIL;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

>>> sv/prescale_count_search_top.sv
// Prescale/count search: for a tick total, returns the prescale p and count c
// (c <= 2^width-1) whose product comes closest to the total from below; one
// item at a time. A total that fits the count limit gives its result after the
// fit check. Otherwise a 32-step divider finds the minimum prescale, and a
// rejected total gives its result once that division is done. Each scanned
// prescale costs another division plus capture and update, with up to
// prescale_limit - pmin + 1 candidates, ending early at zero error. The block
// is ready for the next item once the result is loaded; a result not yet taken
// stalls the block, once the next result is ready, until it is taken.
// The shared divider works one quotient bit per cycle.
// Depends on pcs_pkg, pcs_ctrl, pcs_datapath and pcs_div.
module prescale_count_search_top
    import pcs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [TICKS_BITS-1:0]     ticks,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [PRESCALE_BITS-1:0]  prescale,
    output logic [TICKS_BITS-1:0]     count,
    output logic                      status
);

    pcs_cmd_t cmd;
    pcs_sts_t sts;

    // Register writes are taken in any cycle
    assign cfg_ready = 1'b1;

    pcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pcs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ticks     (ticks),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .prescale  (prescale),
        .count     (count),
        .status    (status)
    );

endmodule

>>> sv/pcs_checker.sv
// Port-level checks for the prescale/count search top level, bound to it below.
// Depends on pcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcs_checker
    import pcs_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [PRESCALE_BITS-1:0]  prescale,
    input logic [TICKS_BITS-1:0]     count,
    input logic                      status
);

    logic                                out_wait;
    logic [PRESCALE_BITS+TICKS_BITS:0]   out_item;

    assign out_wait = out_valid && !out_ready;
    assign out_item = {prescale, count, status};

    // Hold a pending result until it is taken
    `ASSERT_PROP(a_out_hold, out_wait |=> (out_valid && $stable(out_item)), "result not held")
    // Failure results carry zero prescale and count
    `ASSERT_NEVER(a_fail_zero, out_valid && status && (|{prescale, count}), "fail not zeroed")
    // Successful results carry a nonzero prescale
    `ASSERT_NEVER(a_ok_prescale, out_valid && !status && prescale == '0, "zero prescale")
    // Drop ready after taking an item while it is worked on
    `ASSERT_PROP(a_busy, (in_valid && in_ready) |=> !in_ready, "ready high after accept")

endmodule

bind prescale_count_search_top pcs_checker u_pcs_checker (.*);
